@@ rtl/positional_list_engine_unit_macros.svh @@
// Assertion macros used by the top RTL file of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned COUNT_OUT_W  = 5;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_RETRIEVE = 2'd2,
        OP_REPLACE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every storage cell.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rep;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/ple_cell.sv @@
`default_nettype none

// One list slot. It compares its own index with the broadcast position and
// takes its left neighbor on insert, its right neighbor on delete, or the
// new value when it is the addressed slot.
module ple_cell #(
    parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
    parameter int unsigned IDX      = 0
) (
    input  wire logic                        i_clk,
    input  wire ple_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic [ple_pkg::DATA_W-1:0]  i_value,
    input  wire logic [ple_pkg::DATA_W-1:0]  i_left,
    input  wire logic [ple_pkg::DATA_W-1:0]  i_right,
    output logic      [ple_pkg::DATA_W-1:0]  o_entry,
    output logic      [ple_pkg::DATA_W-1:0]  o_rd
);

    localparam int unsigned IdxW = $clog2(CAPACITY);
    localparam int unsigned CmpW = (IdxW > ple_pkg::POS_W) ? IdxW : ple_pkg::POS_W;
    localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX);

    logic [ple_pkg::DATA_W-1:0] r_entry;
    logic [ple_pkg::DATA_W-1:0] n_entry;
    logic [CmpW-1:0]            w_pos;
    logic                       w_at;
    logic                       w_after;

    assign w_pos   = CmpW'(i_ctrl.pos);
    assign w_at    = (MyIdx == w_pos);
    assign w_after = (MyIdx > w_pos);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_after) begin
                n_entry = i_left;
            end else if (w_at) begin
                n_entry = i_value;
            end
        end else if (i_ctrl.del) begin
            if (w_at || w_after) begin
                n_entry = i_right;
            end
        end else if (i_ctrl.rep && w_at) begin
            n_entry = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_rd    = r_entry & {ple_pkg::DATA_W{w_at}};

endmodule

`default_nettype wire

@@ rtl/positional_list_engine_unit.sv @@
// Positional list engine: an ordered list of signed 32-bit entries held in a
// row of storage cells, one entry per cell, with a fill count.
// Input channel: i_valid, o_stall, i_op, i_pos, i_value. A transfer happens
// at a rising edge with i_valid high and o_stall low. Operations are insert,
// delete, retrieve and replace at a zero-based position.
// Output channel: o_valid, i_stall, o_value_out, o_count, o_status. Exactly
// one result follows every input transfer, in order.
// The result is registered at the edge of the input transfer. Throughput is
// one operation per cycle while o_stall is low, set by the cells: on insert
// or delete the cells from the position on are updated in parallel.
// While the receiver stalls and a result is held, o_stall is raised and the
// held result does not change; a new input is taken in the same cycle the
// held result leaves.
// Synchronous reset (i_rst_n low) empties the list and drops any held
// result. Cell contents are not reset; no operation reads past the count.
// A bad position or an insert into a full list is flagged in o_status and
// leaves the list unchanged.
`default_nettype none
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit #(
    parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_op,
    input  wire logic [ple_pkg::POS_W-1:0]       i_pos,
    input  wire logic signed [ple_pkg::DATA_W-1:0] i_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [ple_pkg::DATA_W-1:0]    o_value_out,
    output logic      [ple_pkg::COUNT_OUT_W-1:0] o_count,
    output logic      [ple_pkg::STATUS_W-1:0]    o_status
);

    // The fill count must hold the capacity itself; comparisons against the
    // position run at the wider of the two widths.
    localparam int unsigned CntW = $clog2(CAPACITY + 1);
    localparam int unsigned CmpW = (CntW > ple_pkg::POS_W) ? CntW : ple_pkg::POS_W;

    logic [CntW-1:0]                   r_fill;
    logic [CntW-1:0]                   n_fill;
    logic                              r_valid;
    logic [ple_pkg::DATA_W-1:0]        r_value_out;
    logic [ple_pkg::COUNT_OUT_W-1:0]   r_out_count;
    ple_pkg::t_status                  r_status;

    logic                              w_in_acc;
    ple_pkg::t_op                      w_op;
    ple_pkg::t_status                  w_status;
    logic                              w_ok;
    logic [CmpW-1:0]                   w_pos_x;
    logic [CmpW-1:0]                   w_fill_x;
    logic [CmpW-1:0]                   w_nfill_x;
    logic [ple_pkg::DATA_W-1:0]        w_rd;
    logic [ple_pkg::DATA_W-1:0]        w_res;
    ple_pkg::t_cell_ctrl               w_ctrl;

    logic [ple_pkg::DATA_W-1:0]        w_entry [CAPACITY];
    logic [ple_pkg::DATA_W-1:0]        w_cell_rd [CAPACITY];

    // The input side is held off only while a finished result is waiting.
    assign o_stall  = r_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;

    assign w_op     = ple_pkg::t_op'(i_op);
    assign w_pos_x  = CmpW'(i_pos);
    assign w_fill_x = CmpW'(r_fill);

    // Status: for insert the full check comes before the position check.
    always_comb begin
        w_status = ple_pkg::ST_OK;
        if (w_op == ple_pkg::OP_INSERT) begin
            if (r_fill == CntW'(CAPACITY)) begin
                w_status = ple_pkg::ST_FULL;
            end else if (w_pos_x > w_fill_x) begin
                w_status = ple_pkg::ST_RANGE;
            end
        end else if (w_pos_x >= w_fill_x) begin
            w_status = ple_pkg::ST_RANGE;
        end
    end

    assign w_ok = (w_status == ple_pkg::ST_OK);

    // Command for the cells; only a successful transfer changes the list.
    always_comb begin
        w_ctrl.ins = w_in_acc && w_ok && (w_op == ple_pkg::OP_INSERT);
        w_ctrl.del = w_in_acc && w_ok && (w_op == ple_pkg::OP_DELETE);
        w_ctrl.rep = w_in_acc && w_ok && (w_op == ple_pkg::OP_REPLACE);
        w_ctrl.pos = i_pos;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_ctrl.ins) begin
            n_fill = r_fill + CntW'(1);
        end else if (w_ctrl.del) begin
            n_fill = r_fill - CntW'(1);
        end
    end

    assign w_nfill_x = CmpW'(n_fill);

    // The row of cells. Each cell sees its neighbors' entries; the ends of
    // the row take the input value, which is never kept there in a way that
    // reaches a result.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ple_pkg::DATA_W-1:0] w_left;
        logic [ple_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_inner_l
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = i_value;
        end else begin : g_inner_r
            assign w_right = w_entry[g+1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    // At most one cell matches the position, so the read is an OR of the
    // masked cell outputs.
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_cell_rd[k];
        end
    end

    assign w_res = (w_ok && (w_op == ple_pkg::OP_DELETE || w_op == ple_pkg::OP_RETRIEVE))
                   ? w_rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (!o_stall) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value_out <= w_res;
            r_out_count <= w_nfill_x[ple_pkg::COUNT_OUT_W-1:0];
            r_status    <= w_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_value_out;
    assign o_count     = r_out_count;
    assign o_status    = r_status;

    `PLE_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CntW'(CAPACITY))
    `PLE_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_valid && (r_status != ple_pkg::ST_OK), r_value_out == '0)
    `PLE_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_ctrl.ins, r_fill == $past(r_fill) + CntW'(1))
    `PLE_ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, !w_in_acc, $stable(r_fill))
    `PLE_ASSERT_NEXT(a_count_match, i_clk, i_rst_n, w_in_acc, r_out_count == w_fill_x[ple_pkg::COUNT_OUT_W-1:0])

endmodule

`default_nettype wire
